FILE: sv/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// shared types and constants for the length-prefixed frame receiver
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = 9;

    localparam logic [7:0] CH_START  = 8'h23;
    localparam logic [7:0] CH_SECOND = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CLOSE  = 8'h26;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_ABORT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_WAIT_STAR,
        PH_CHECK,
        PH_WAIT_END
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic [7:0]       payload_index;
        logic             payload_last;
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       check_byte;
        logic             length_error;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

FILE: sv/length_prefixed_frame_receiver_core.sv
// path: an accepted item waits in the input register, then its result is held in the result register
// throughput: one item per cycle while the result is not stalled; the phase update is a single step of logic
// a stalled result holds while one more item waits in the input register
// reset: rst_n asynchronous, active low; phase returns to idle, counters and
// saved length and check byte clear, both registers empty
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core
// recognizes '#' '!' len16 payload '*' check '&' frames in a byte stream
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      payload_valid,
    output logic [7:0]                payload_byte,
    output logic [7:0]                payload_index,
    output logic                      payload_last,
    output logic                      frame_done,
    output logic [lpfr_pkg::LEN_W-1:0] frame_length,
    output logic [7:0]                check_byte,
    output logic                      length_error
);
    import lpfr_pkg::*;

    stage_t  s1;
    result_t result;
    result_t out_result;
    logic    out_free;

    lpfr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .out_free (out_free),
        .s1       (s1)
    );

    lpfr_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1      (s1),
        .advance (s1.valid && out_free),
        .result  (result)
    );

    lpfr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1.valid),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign payload_valid = out_result.payload_valid;
    assign payload_byte  = out_result.payload_byte;
    assign payload_index = out_result.payload_index;
    assign payload_last  = out_result.payload_last;
    assign frame_done    = out_result.frame_done;
    assign frame_length  = out_result.frame_length;
    assign check_byte    = out_result.check_byte;
    assign length_error  = out_result.length_error;

endmodule

FILE: sv/lpfr_in_stage.sv
// ----------------------------------------------------------------------------
// lpfr_in_stage
// input register, holds one item until the result register can take it
// ----------------------------------------------------------------------------
module lpfr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           mode,
    input  logic [7:0]     rx_byte,
    input  logic           out_free,
    output lpfr_pkg::stage_t s1
);
    import lpfr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_stall   = valid_reg && !out_free;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode    <= mode;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign s1.valid = valid_reg;
    assign s1.item  = item_reg;

endmodule

FILE: sv/lpfr_deframer.sv
// ----------------------------------------------------------------------------
// lpfr_deframer
// frame phase tracking and per-item result decode
// ----------------------------------------------------------------------------
module lpfr_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  lpfr_pkg::stage_t  s1,
    input  logic              advance,
    output lpfr_pkg::result_t result
);
    import lpfr_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [7:0]       len_hi_reg;
    logic [7:0]       len_hi_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       index_reg;
    logic [7:0]       index_next;
    logic [7:0]       check_reg;
    logic [7:0]       check_next;

    logic [15:0]      rx_len;
    logic             len_bad;
    logic             last_byte;
    logic [7:0]       b;

    assign b         = s1.item.rx_byte;
    assign rx_len    = {len_hi_reg, b};
    assign len_bad   = (rx_len == 16'd0) || (rx_len > 16'(MAX_PAYLOAD));
    assign last_byte = ({1'b0, index_reg} + LEN_W'(1)) >= len_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        index_next  = index_reg;
        check_next  = check_reg;
        result      = '0;
        if (s1.item.mode == MODE_ABORT)
        begin
            phase_next = PH_IDLE;
            index_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (b == CH_START)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_START:
                begin
                    if (b == CH_SECOND)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = rx_len[LEN_W-1:0];
                    index_next = '0;
                    if (len_bad)
                    begin
                        result.length_error = 1'b1;
                        phase_next          = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = b;
                    result.payload_index = index_reg;
                    if (last_byte)
                    begin
                        result.payload_last = 1'b1;
                        index_next          = '0;
                        phase_next          = PH_WAIT_STAR;
                    end
                    else
                    begin
                        index_next = index_reg + 8'd1;
                    end
                end
                PH_WAIT_STAR:
                begin
                    if (b == CH_STAR)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_next = b;
                    phase_next = PH_WAIT_END;
                end
                PH_WAIT_END:
                begin
                    if (b == CH_CLOSE)
                    begin
                        result.frame_done   = 1'b1;
                        result.frame_length = len_reg;
                        result.check_byte   = check_reg;
                        phase_next          = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_hi_reg <= '0;
            len_reg    <= '0;
            index_reg  <= '0;
            check_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            index_reg  <= index_next;
            check_reg  <= check_next;
        end
    end

endmodule

FILE: sv/lpfr_out_stage.sv
// ----------------------------------------------------------------------------
// lpfr_out_stage
// result register with valid/stall handshake toward the consumer
// ----------------------------------------------------------------------------
module lpfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  lpfr_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output lpfr_pkg::result_t out_result
);
    import lpfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    load;

    assign out_free   = !valid_reg || !out_stall;
    assign load       = s1_valid && out_free;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: sv/lpfr_checker.sv
// ----------------------------------------------------------------------------
// lpfr_checker
// port-level checks on the frame receiver result stream
// ----------------------------------------------------------------------------
module lpfr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       payload_valid,
    input logic [7:0]                 payload_byte,
    input logic [7:0]                 payload_index,
    input logic                       payload_last,
    input logic                       frame_done,
    input logic [lpfr_pkg::LEN_W-1:0] frame_length,
    input logic [7:0]                 check_byte,
    input logic                       length_error
);
    import lpfr_pkg::*;

    // result kinds never overlap
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({payload_valid, frame_done, length_error}))
        else $error("more than one result kind in one item");

    // payload fields are zero outside payload bytes
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !payload_valid) |->
            (payload_byte == 8'd0 && payload_index == 8'd0 && !payload_last))
        else $error("payload fields set without payload_valid");

    // completed frame length is within the legal range, zero otherwise
    a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_done
            ? (frame_length != '0 && frame_length <= LEN_W'(MAX_PAYLOAD))
            : (frame_length == '0 && check_byte == 8'd0)))
        else $error("frame_length or check_byte out of range");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(payload_index)
            && $stable(frame_length) && $stable(payload_valid)))
        else $error("result changed while stalled");

endmodule

bind length_prefixed_frame_receiver_core lpfr_checker u_lpfr_checker (.*);
